>>> rtl/cnc_pkg.sv
package cnc_pkg;

    localparam int unsigned CharWidth  = 8;
    localparam int unsigned CountWidth = 5;
    localparam int unsigned DigitWidth = 4;
    localparam int unsigned CfgAddrWidth = 2;

    localparam logic [CountWidth-1:0] CountMax     = 5'd31;
    localparam logic [CountWidth-1:0] MinLengthRst = 5'd13;
    localparam logic [CountWidth-1:0] MaxLengthRst = 5'd19;

    localparam logic [CharWidth-1:0] CharSpace = 8'h20;
    localparam logic [CharWidth-1:0] CharTab   = 8'h09;
    localparam logic [CharWidth-1:0] CharCr    = 8'h0D;
    localparam logic [CharWidth-1:0] CharZero  = 8'h30;
    localparam logic [CharWidth-1:0] CharNine  = 8'h39;

    localparam logic [DigitWidth-1:0] DigitThree = 4'd3;
    localparam logic [DigitWidth-1:0] DigitFour  = 4'd4;
    localparam logic [DigitWidth-1:0] DigitFive  = 4'd5;
    localparam logic [DigitWidth-1:0] DigitSix   = 4'd6;
    localparam logic [DigitWidth-1:0] DigitSeven = 4'd7;

    localparam logic [CfgAddrWidth-1:0] RegMinLength = 2'd0;
    localparam logic [CfgAddrWidth-1:0] RegMaxLength = 2'd1;

    typedef enum logic [1:0] {
        STATUS_VALID      = 2'd0,
        STATUS_BAD_CHAR   = 2'd1,
        STATUS_BAD_LENGTH = 2'd2,
        STATUS_LUHN_FAIL  = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        CARD_OTHER      = 3'd0,
        CARD_VISA       = 3'd1,
        CARD_MASTERCARD = 3'd2,
        CARD_MAESTRO    = 3'd3,
        CARD_JCB        = 3'd4,
        CARD_AMEX       = 3'd5
    } card_type_t;

    typedef struct packed {
        status_t                 status;
        card_type_t              card_type;
        logic [CountWidth-1:0]   digit_total;
    } result_t;

    function automatic logic is_blank(input logic [CharWidth-1:0] c);
        return (c == CharSpace) || ((c >= CharTab) && (c <= CharCr));
    endfunction

    function automatic logic is_digit(input logic [CharWidth-1:0] c);
        return (c >= CharZero) && (c <= CharNine);
    endfunction

    // sum and addend are both below ten
    function automatic logic [DigitWidth-1:0] add_mod10(input logic [DigitWidth-1:0] s,
                                                       input logic [DigitWidth-1:0] v);
        logic [DigitWidth:0] t;
        t = {1'b0, s} + {1'b0, v};
        return (t >= 5'd10) ? DigitWidth'(t - 5'd10) : DigitWidth'(t);
    endfunction

    function automatic logic [DigitWidth-1:0] doubled(input logic [DigitWidth-1:0] d);
        logic [DigitWidth:0] t;
        t = {d, 1'b0};
        return (t > 5'd9) ? DigitWidth'(t - 5'd9) : DigitWidth'(t);
    endfunction

    function automatic card_type_t classify(input logic [DigitWidth-1:0] first,
                                            input logic [DigitWidth-1:0] second);
        card_type_t ct;
        unique case (first)
            DigitThree: begin
                ct = ((second == DigitFour) || (second == DigitSeven)) ? CARD_AMEX : CARD_JCB;
            end
            DigitFour:  ct = CARD_VISA;
            DigitFive:  ct = CARD_MASTERCARD;
            DigitSix:   ct = CARD_MAESTRO;
            default:    ct = CARD_OTHER;
        endcase
        return ct;
    endfunction

endpackage

>>> rtl/cnc_number_acc.sv
module cnc_number_acc
    import cnc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  take,
    input  logic [CharWidth-1:0]  char_code,
    input  logic                  last_char,
    input  logic [CountWidth-1:0] min_length,
    input  logic [CountWidth-1:0] max_length,
    output result_t               res
);

    logic [CountWidth-1:0] count_reg,  count_next;
    logic [DigitWidth-1:0] even_reg,   even_next;
    logic [DigitWidth-1:0] odd_reg,    odd_next;
    logic                  bad_reg,    bad_next;
    logic                  ovf_reg,    ovf_next;
    logic [DigitWidth-1:0] first_reg,  first_next;
    logic [DigitWidth-1:0] second_reg, second_next;

    logic [DigitWidth-1:0] digit;
    logic [DigitWidth-1:0] dbl;
    logic [DigitWidth-1:0] luhn;

    assign digit = DigitWidth'(char_code - CharZero);
    assign dbl   = doubled(digit);

    // updated number state for the item in hand
    always_comb begin
        count_next  = count_reg;
        even_next   = even_reg;
        odd_next    = odd_reg;
        bad_next    = bad_reg;
        ovf_next    = ovf_reg;
        first_next  = first_reg;
        second_next = second_reg;
        if (!is_blank(char_code)) begin
            if (!is_digit(char_code)) begin
                bad_next = 1'b1;
            end else if (count_reg == CountMax) begin
                ovf_next = 1'b1;
            end else begin
                if (count_reg == 5'd0) begin
                    first_next = digit;
                end
                if (count_reg == 5'd1) begin
                    second_next = digit;
                end
                if (count_reg[0]) begin
                    even_next = add_mod10(even_reg, dbl);
                    odd_next  = add_mod10(odd_reg, digit);
                end else begin
                    even_next = add_mod10(even_reg, digit);
                    odd_next  = add_mod10(odd_reg, dbl);
                end
                count_next = count_reg + 5'd1;
            end
        end
    end

    // rightmost digit is plain in the sum matching its position parity
    assign luhn = count_next[0] ? even_next : odd_next;

    always_comb begin
        if (bad_next) begin
            res.status = STATUS_BAD_CHAR;
        end else if (ovf_next || (count_next < min_length) || (count_next > max_length)) begin
            res.status = STATUS_BAD_LENGTH;
        end else if (luhn != 4'd0) begin
            res.status = STATUS_LUHN_FAIL;
        end else begin
            res.status = STATUS_VALID;
        end
        res.card_type   = classify(first_next, second_next);
        res.digit_total = count_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (take && last_char)) begin
            count_reg  <= '0;
            even_reg   <= '0;
            odd_reg    <= '0;
            bad_reg    <= 1'b0;
            ovf_reg    <= 1'b0;
            first_reg  <= '0;
            second_reg <= '0;
        end else if (take) begin
            count_reg  <= count_next;
            even_reg   <= even_next;
            odd_reg    <= odd_next;
            bad_reg    <= bad_next;
            ovf_reg    <= ovf_next;
            first_reg  <= first_next;
            second_reg <= second_next;
        end
    end

endmodule

>>> rtl/card_number_check_classify_unit.sv
// Card number check and classify unit.
// Input channel (s_): one ASCII character per item, s_last_char marking the
// final character of a card number. Blanks are skipped, digits feed two
// running Luhn sums, anything else flags the number as bad.
// Result channel (m_): one item per card number, produced by the final
// character: status, card type from the leading digits, and digit count.
// Config port: cfg_wr_en/cfg_addr/cfg_wdata write min_length (0) and
// max_length (1); other indices are ignored. Write only while idle.
// Path: the accepting edge loads the input register with the character; the
// result register loads the final character's result when the character
// is taken from the input register, which a waiting result can delay.
// Throughput: one character per cycle while no final character is held;
// the running state updates from each character taken from the input register.
// Reset (aresetn low, synchronous): both registers empty, number state
// cleared, bounds back to 13 and 19.
// Stall: while a result waits on m_ready, non-final characters still flow
// through; a final character holds in the input register, and s_ready
// drops once that register cannot drain.
module card_number_check_classify_unit
    import cnc_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    // configuration
    input  logic                    cfg_wr_en,
    input  logic [CfgAddrWidth-1:0] cfg_addr,
    input  logic [CountWidth-1:0]   cfg_wdata,
    // input items
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [CharWidth-1:0]    s_char_code,
    input  logic                    s_last_char,
    // result items
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [1:0]              m_status,
    output logic [2:0]              m_card_type,
    output logic [CountWidth-1:0]   m_digit_total
);

    logic [CountWidth-1:0] min_length_reg;
    logic [CountWidth-1:0] max_length_reg;

    // input register
    logic                 in_valid_reg;
    logic [CharWidth-1:0] in_char_reg;
    logic                 in_last_reg;

    // result register
    logic                 out_valid_reg;
    result_t              out_reg;

    logic    out_free;
    logic    take;
    result_t res;

    // a final character needs the result slot; others drain freely
    assign out_free = !out_valid_reg || m_ready;
    assign take     = in_valid_reg && (!in_last_reg || out_free);
    assign s_ready  = !in_valid_reg || take;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_length_reg <= MinLengthRst;
            max_length_reg <= MaxLengthRst;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                RegMinLength: min_length_reg <= cfg_wdata;
                RegMaxLength: max_length_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_char_reg <= s_char_code;
            in_last_reg <= s_last_char;
        end
    end

    cnc_number_acc u_acc (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .take       (take),
        .char_code  (in_char_reg),
        .last_char  (in_last_reg),
        .min_length (min_length_reg),
        .max_length (max_length_reg),
        .res        (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (take && in_last_reg) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (take && in_last_reg) begin
            out_reg <= res;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_status      = out_reg.status;
    assign m_card_type   = out_reg.card_type;
    assign m_digit_total = out_reg.digit_total;

endmodule
